// File: rtl/learning_switch_forward_defines.svh
// Assertion macros for the learning switch forwarding block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef LEARNING_SWITCH_FORWARD_DEFINES_SVH
`define LEARNING_SWITCH_FORWARD_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSF_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lsf_pkg.sv
// Shared types and constants of the learning switch forwarding block.
// No dependencies; used by the interfaces and the top level.
package lsf_pkg;

    localparam int MASK_W  = 8;
    localparam int PORT_W  = 3;
    localparam int CFG_W   = 4;
    localparam int TOTAL_W = 32;

    localparam logic [CFG_W-1:0] ACTIVE_PORTS_RESET = 4'd8;

    typedef enum logic [1:0] {
        ACT_UNICAST = 2'd0,
        ACT_FLOOD   = 2'd1,
        ACT_DROP    = 2'd2
    } action_t;

endpackage

// File: rtl/lsf_if.sv
// Handshake channels of the learning switch forwarding block.
// Depends on lsf_pkg for field widths and the action code type.
interface lsf_frame_if #(parameter int ADDR_BITS = 48);
    logic                        valid;
    logic                        ready;
    logic [ADDR_BITS-1:0]        src_addr;
    logic [ADDR_BITS-1:0]        dst_addr;
    logic [lsf_pkg::PORT_W-1:0]  in_port;

    modport source (output valid, src_addr, dst_addr, in_port, input ready);
    modport sink   (input valid, src_addr, dst_addr, in_port, output ready);
endinterface

interface lsf_result_if;
    logic                        valid;
    logic                        ready;
    logic [lsf_pkg::MASK_W-1:0]  port_mask;
    lsf_pkg::action_t            action;
    logic                        learned;
    logic [lsf_pkg::TOTAL_W-1:0] forwarded_total;
    logic [lsf_pkg::TOTAL_W-1:0] flood_total;

    modport source (output valid, port_mask, action, learned, forwarded_total, flood_total,
                    input ready);
    modport sink   (input valid, port_mask, action, learned, forwarded_total, flood_total,
                    output ready);
endinterface

interface lsf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lsf_pkg::CFG_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/lsf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lsf_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/learning_switch_forward.sv
// Learning switch forwarding: station table scan, learn and port decision.
// Depends on lsf_pkg, lsf_if, lsf_ram and learning_switch_forward_defines.svh.
//
//  channel  dir  handshake     payload
//  cfg      in   valid/ready   data: active_ports
//  frame    in   valid/ready   src_addr, dst_addr, in_port
//  result   out  valid/ready   port_mask, action, learned, forwarded_total, flood_total
//
// A frame is accepted only in the idle state; the scan state then reads each learned
// station, followed by the tail and finish states; an empty table goes straight to finish.
// The scan is set by the single read port of the station RAM: one entry per cycle,
// compared against source and destination at once.
// Reset empties the table by clearing its fill count; no clearing pass is needed.
// The result register lets a new frame in while the previous word waits; a frame that
// finishes while the result is still held waits in the final state.
`include "learning_switch_forward_defines.svh"

module learning_switch_forward #(
    parameter int NUM_PORTS   = 8,
    parameter int TABLE_DEPTH = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    lsf_cfg_if.sink      cfg,
    lsf_frame_if.sink    frame,
    lsf_result_if.source result
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int PW   = lsf_pkg::PORT_W;
    localparam int MW   = lsf_pkg::MASK_W;
    localparam int TW   = lsf_pkg::TOTAL_W;
    localparam int RAMW = ADDR_BITS + PW;
    localparam logic [lsf_pkg::CFG_W-1:0] PORT_LIM =
        lsf_pkg::CFG_W'((NUM_PORTS < MW) ? NUM_PORTS : MW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDXW-1:0]            scan_idx_reg, scan_idx_next;
    logic                       rd_valid_reg, rd_valid_next;
    logic                       src_found_reg, src_found_next;
    logic                       dst_found_reg, dst_found_next;
    logic [PW-1:0]              dst_port_reg, dst_port_next;
    logic [CNTW-1:0]            count_reg, count_next;
    logic [lsf_pkg::CFG_W-1:0]  active_reg, active_next;
    logic [TW-1:0]              fwd_reg, fwd_next;
    logic [TW-1:0]              fld_reg, fld_next;
    logic                       out_valid_reg, out_valid_next;
    logic [MW-1:0]              out_mask_reg, out_mask_next;
    lsf_pkg::action_t           out_action_reg, out_action_next;
    logic                       out_learned_reg, out_learned_next;

    logic [ADDR_BITS-1:0]       src_reg;
    logic [ADDR_BITS-1:0]       dst_reg;
    logic [PW-1:0]              port_reg;

    logic                       ram_we;
    logic                       ram_re;
    logic [RAMW-1:0]            ram_rdata;
    logic                       hit_src;
    logic                       hit_dst;
    logic                       learn;
    logic                       dst_hit;
    logic [PW-1:0]              dst_port;
    logic [lsf_pkg::CFG_W-1:0]  limit;
    logic [MW-1:0]              flood_mask;
    logic                       frame_accept;

    lsf_ram #(
        .WIDTH (RAMW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDXW-1:0]),
        .wdata ({port_reg, src_reg}),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign cfg.ready          = 1'b1;
    assign frame.ready        = (state_reg == S_IDLE);
    assign frame_accept       = frame.valid && frame.ready;
    assign result.valid       = out_valid_reg;
    assign result.port_mask   = out_mask_reg;
    assign result.action      = out_action_reg;
    assign result.learned     = out_learned_reg;
    assign result.forwarded_total = fwd_reg;
    assign result.flood_total = fld_reg;

    assign hit_src = rd_valid_reg && (ram_rdata[ADDR_BITS-1:0] == src_reg);
    assign hit_dst = rd_valid_reg && (ram_rdata[ADDR_BITS-1:0] == dst_reg);

    assign learn    = !src_found_reg && (count_reg < CNTW'(TABLE_DEPTH));
    assign dst_hit  = dst_found_reg || (learn && (dst_reg == src_reg));
    assign dst_port = dst_found_reg ? dst_port_reg : port_reg;
    assign limit    = (active_reg > PORT_LIM) ? PORT_LIM : active_reg;

    always_comb
    begin
        for (int i = 0; i < MW; i++)
        begin
            flood_mask[i] = (lsf_pkg::CFG_W'(i) < limit) && (PW'(i) != port_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        rd_valid_next    = 1'b0;
        src_found_next   = src_found_reg;
        dst_found_next   = dst_found_reg;
        dst_port_next    = dst_port_reg;
        count_next       = count_reg;
        active_next      = active_reg;
        fwd_next         = fwd_reg;
        fld_next         = fld_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_mask_next    = out_mask_reg;
        out_action_next  = out_action_reg;
        out_learned_next = out_learned_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        if (cfg.valid)
        begin
            active_next = cfg.data;
        end

        if (hit_src)
        begin
            src_found_next = 1'b1;
        end
        if (hit_dst && !dst_found_reg)
        begin
            dst_found_next = 1'b1;
            dst_port_next  = ram_rdata[RAMW-1:ADDR_BITS];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    src_found_next = 1'b0;
                    dst_found_next = 1'b0;
                    scan_idx_next  = '0;
                    state_next     = (count_reg == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                ram_re        = 1'b1;
                rd_valid_next = 1'b1;
                if (CNTW'(scan_idx_reg) == CNTW'(count_reg - CNTW'(1)))
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDXW'(1);
                end
            end
            S_TAIL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    ram_we           = learn;
                    count_next       = count_reg + CNTW'(learn);
                    out_valid_next   = 1'b1;
                    out_learned_next = learn;
                    if (dst_hit && (dst_port != port_reg))
                    begin
                        out_mask_next   = MW'(1) << dst_port;
                        out_action_next = lsf_pkg::ACT_UNICAST;
                        fwd_next        = fwd_reg + TW'(1);
                    end
                    else if (dst_hit)
                    begin
                        out_mask_next   = '0;
                        out_action_next = lsf_pkg::ACT_DROP;
                    end
                    else
                    begin
                        out_mask_next   = flood_mask;
                        out_action_next = lsf_pkg::ACT_FLOOD;
                        if (flood_mask != '0)
                        begin
                            fwd_next = fwd_reg + TW'(1);
                            fld_next = fld_reg + TW'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            src_found_reg   <= 1'b0;
            dst_found_reg   <= 1'b0;
            dst_port_reg    <= '0;
            count_reg       <= '0;
            active_reg      <= lsf_pkg::ACTIVE_PORTS_RESET;
            fwd_reg         <= '0;
            fld_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_mask_reg    <= '0;
            out_action_reg  <= lsf_pkg::ACT_UNICAST;
            out_learned_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            rd_valid_reg    <= rd_valid_next;
            src_found_reg   <= src_found_next;
            dst_found_reg   <= dst_found_next;
            dst_port_reg    <= dst_port_next;
            count_reg       <= count_next;
            active_reg      <= active_next;
            fwd_reg         <= fwd_next;
            fld_reg         <= fld_next;
            out_valid_reg   <= out_valid_next;
            out_mask_reg    <= out_mask_next;
            out_action_reg  <= out_action_next;
            out_learned_reg <= out_learned_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_accept)
        begin
            src_reg  <= frame.src_addr[ADDR_BITS-1:0];
            dst_reg  <= frame.dst_addr[ADDR_BITS-1:0];
            port_reg <= frame.in_port;
        end
    end

    `LSF_CHECK(a_count_bound, 1'b1, count_reg <= CNTW'(TABLE_DEPTH),
        "station count beyond table depth")
    `LSF_CHECK_NEXT(a_accept_busy, frame_accept, state_reg != S_IDLE,
        "frame accepted but block still idle")
    `LSF_CHECK_NEXT(a_learn_count, ram_we, count_reg == $past(count_reg) + CNTW'(1),
        "table write without count advance")
    `LSF_CHECK(a_scan_range, state_reg == S_SCAN, CNTW'(scan_idx_reg) < count_reg,
        "scan beyond learned entries")
    `LSF_CHECK(a_drop_mask, out_valid_reg && (out_action_reg == lsf_pkg::ACT_DROP),
        out_mask_reg == '0, "dropped frame carries a port mask")

endmodule
